// ===== src/pa_pkg.sv =====
// Shared types, constants and codes for the positional array list.
package pa_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = 7;
    localparam int CNT_W    = 8;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 3;

    localparam int GROUP    = 16;
    localparam int NGRP     = CAPACITY / GROUP;
    localparam int LOC_W    = $clog2(GROUP);
    localparam int GRP_W    = $clog2(NGRP);

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_CMP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
        logic [CNT_W-1:0]   count;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

// ===== src/pa_cell.sv =====
// One storage cell of the list: holds one word and shifts with its neighbors.
module pa_cell (
    input  logic                     aclk,
    input  pa_pkg::cell_cmd_t        cmd,
    input  logic [pa_pkg::IDX_W-1:0] idx,
    input  logic [pa_pkg::DATA_W-1:0] left_data,
    input  logic [pa_pkg::DATA_W-1:0] right_data,
    output logic [pa_pkg::DATA_W-1:0] data,
    output logic                     match
);
    import pa_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;

    always_comb begin
        data_next  = data_reg;
        match_next = match_reg;
        case (cmd.op)
            CELL_INS: begin
                if (idx > cmd.pos) begin
                    data_next = left_data;
                end else if (idx == cmd.pos) begin
                    data_next = cmd.value;
                end
            end
            CELL_DEL: begin
                if (idx >= cmd.pos) begin
                    data_next = right_data;
                end
            end
            CELL_CMP: begin
                // Entries at or above the count are not part of the list.
                match_next = (data_reg == cmd.value) && ({1'b0, idx} < cmd.count);
            end
            default: begin
                data_next  = data_reg;
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== src/pa_first_match.sv =====
// Two-level priority encoder that finds the lowest set match flag.
module pa_first_match (
    input  logic                        aclk,
    input  logic [pa_pkg::CAPACITY-1:0] match_vec,
    output logic                        found,
    output logic [pa_pkg::IDX_W-1:0]    found_idx
);
    import pa_pkg::*;

    logic             grp_hit_reg [NGRP];
    logic [LOC_W-1:0] grp_loc_reg [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic             hit_next;
        logic [LOC_W-1:0] loc_next;

        always_comb begin
            hit_next = 1'b0;
            loc_next = '0;
            for (int b = GROUP - 1; b >= 0; b--) begin
                if (match_vec[g*GROUP + b]) begin
                    hit_next = 1'b1;
                    loc_next = LOC_W'(b);
                end
            end
        end

        always_ff @(posedge aclk) begin
            grp_hit_reg[g] <= hit_next;
            grp_loc_reg[g] <= loc_next;
        end
    end

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_hit_reg[g]) begin
                found     = 1'b1;
                found_idx = IDX_W'({GRP_W'(g), grp_loc_reg[g]});
            end
        end
    end

endmodule

// ===== src/positional_array_list_unit.sv =====
// Top level of the positional array list: request control, cell row and result register.
//
// The block keeps an ordered list of up to 128 signed 32-bit words in a row of
// cells. Requests arrive as transfers on the s_ channel: insert a word at a
// position, delete the word at a position, or search for the lowest position
// holding a word. Every request gives exactly one result transfer on the m_
// channel carrying a status, the found position, the removed word and the
// entry count after the request.
//
// One request is worked on at a time. An insert or delete first shifts the
// whole cell row and then loads its result into the output register. A search
// first has every cell compare its word in parallel, then a registered
// priority encoder over groups of 16 cells picks the lowest match, and then
// the result is loaded. A new request is taken in the cycle after a result
// is loaded, so no request is taken before the last one's result is loaded.
//
// After reset the list is empty and no result is pending. When the receiver
// holds m_tready low, the finished result stays in the output register while
// the next request is already accepted and worked on; that request then waits
// for the register to free up before its own result is loaded.
module positional_array_list_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: func[1:0], position[8:2], element[40:9], zero fill.
    input  logic [pa_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: status[2:0], found_index[9:3], removed_value[41:10],
    // entry_count[49:42], zero fill.
    output logic [pa_pkg::M_DATA_W-1:0]   m_tdata
);
    import pa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Registered request.
    logic [FUNC_W-1:0] req_func_reg;
    logic [IDX_W-1:0]  req_pos_reg;
    logic [DATA_W-1:0] req_elem_reg;

    // Entry count and the pending result of a request.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [STAT_W-1:0] res_status_reg;
    logic [STAT_W-1:0] res_status_next;
    logic [DATA_W-1:0] res_removed_reg;
    logic [DATA_W-1:0] res_removed_next;

    // Output register.
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Cell row.
    cell_cmd_t         cell_cmd;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    logic              scan_found;
    logic [IDX_W-1:0]  scan_idx;

    logic              s_accept;
    logic              load_out;
    logic [STAT_W-1:0] out_status;
    logic [IDX_W-1:0]  out_idx;
    logic              is_search;

    assign s_accept  = s_tvalid && s_tready;
    assign is_search = (req_func_reg == FUNC_SEARCH);

    // The cell row. On an insert, cells above the position take their left neighbor's word;
    // on a delete, cells at or above it take their right neighbor's word; the ends see zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_data[i+1];
        end

        pa_cell u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .idx        (IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    pa_first_match u_first_match (
        .aclk      (aclk),
        .match_vec (match_vec),
        .found     (scan_found),
        .found_idx (scan_idx)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = is_search ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell command, status decision and result load.
    always_comb begin
        s_tready         = 1'b0;
        load_out         = 1'b0;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        cell_cmd.op      = CELL_HOLD;
        cell_cmd.pos     = req_pos_reg;
        cell_cmd.value   = req_elem_reg;
        cell_cmd.count   = count_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EXEC: begin
                res_removed_next = '0;
                case (req_func_reg)
                    FUNC_INSERT: begin
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            res_status_next = STAT_FULL;
                        end else if ({1'b0, req_pos_reg} > count_reg) begin
                            res_status_next = STAT_BADPOS;
                        end else begin
                            res_status_next = STAT_DONE;
                            cell_cmd.op     = CELL_INS;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    FUNC_DELETE: begin
                        if (count_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                        end else if ({1'b0, req_pos_reg} >= count_reg) begin
                            res_status_next = STAT_BADPOS;
                        end else begin
                            res_status_next  = STAT_DONE;
                            res_removed_next = cell_data[req_pos_reg];
                            cell_cmd.op      = CELL_DEL;
                            count_next       = count_reg - 1'b1;
                        end
                    end
                    FUNC_SEARCH: begin
                        res_status_next = STAT_NOTFOUND;
                        cell_cmd.op     = CELL_CMP;
                    end
                    default: begin
                        res_status_next = STAT_BADPOS;
                    end
                endcase
            end
            ST_OUT: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // A search takes its status and position from the encoder.
    always_comb begin
        out_status = res_status_reg;
        out_idx    = '0;
        if (is_search && scan_found) begin
            out_status = STAT_DONE;
            out_idx    = scan_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_func_reg <= s_tdata[1:0];
            req_pos_reg  <= s_tdata[8:2];
            req_elem_reg <= s_tdata[40:9];
        end
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        if (load_out) begin
            m_tdata_reg <= {6'd0, count_reg, res_removed_reg, out_idx, out_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
